>>> sv/maf_pkg.sv
// Package for the moving average filter: default sizes, register constants
// and the state types of the front end and the divider.
// No dependencies.
package maf_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;

  // Window length register.
  localparam int                         WINDOW_REG_BITS = 7;
  localparam logic [WINDOW_REG_BITS-1:0] WINDOW_RESET    = 7'd20;

  typedef enum logic {
    FR_IDLE,
    FR_CALC
  } front_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_DONE
  } div_state_t;

endpackage

>>> sv/maf_front.sv
// Front end of the moving average filter: takes samples, keeps the history
// ring and the running window sum, and queues each sum with its window length.
// Depends on maf_pkg.
module maf_front import maf_pkg::*; #(
  parameter int  MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int  SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int WIN_BITS    = $clog2(MAX_WINDOW + 1),
  localparam int SUM_BITS    = SAMPLE_BITS + $clog2(MAX_WINDOW)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [WINDOW_REG_BITS-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          q_full,
  output logic                          q_push,
  output logic signed [SUM_BITS-1:0]    q_sum,
  output logic [WIN_BITS-1:0]           q_win
);

  localparam int PTR_BITS = $clog2(MAX_WINDOW);
  localparam int IDX_BITS = $clog2(2 * MAX_WINDOW);
  localparam int CW       = (WIN_BITS > WINDOW_REG_BITS) ? WIN_BITS : WINDOW_REG_BITS;

  front_state_t                  state_r, state_nxt;
  logic [WINDOW_REG_BITS-1:0]    win_reg_r;
  logic [PTR_BITS-1:0]           ptr_r, ptr_nxt;
  logic [WIN_BITS-1:0]           fill_r, fill_nxt;
  logic signed [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic signed [SAMPLE_BITS-1:0] hist_r [MAX_WINDOW];

  logic [CW-1:0]                 win_ext;
  logic [WIN_BITS-1:0]           win_eff;
  logic [IDX_BITS-1:0]           idx_sum;
  logic [IDX_BITS-1:0]           old_idx;
  logic signed [SAMPLE_BITS-1:0] old_smp;
  logic                          acc;
  logic                          hist_we;

  // Zero means a window of one; anything beyond the ring depth saturates.
  always_comb begin
    win_ext = CW'(win_reg_r);
    if (win_ext == '0) begin
      win_eff = WIN_BITS'(1);
    end else if (win_ext > CW'(MAX_WINDOW)) begin
      win_eff = WIN_BITS'(MAX_WINDOW);
    end else begin
      win_eff = WIN_BITS'(win_ext);
    end
  end

  always_comb begin
    idx_sum = IDX_BITS'(ptr_r) + IDX_BITS'(MAX_WINDOW) - IDX_BITS'(win_eff);
    if (idx_sum >= IDX_BITS'(MAX_WINDOW)) begin
      old_idx = idx_sum - IDX_BITS'(MAX_WINDOW);
    end else begin
      old_idx = idx_sum;
    end
  end

  // The leaving sample exists only once a full window has been written since
  // the last clear; before that it counts as zero, so the ring needs no wipe.
  always_comb begin
    old_smp  = (fill_r >= win_eff) ? rd_data_r : '0;
    sum_nxt  = sum_r
             - {{(SUM_BITS-SAMPLE_BITS){old_smp[SAMPLE_BITS-1]}}, old_smp}
             + {{(SUM_BITS-SAMPLE_BITS){sample_r[SAMPLE_BITS-1]}}, sample_r};
    ptr_nxt  = (ptr_r == PTR_BITS'(MAX_WINDOW - 1)) ? '0 : ptr_r + PTR_BITS'(1);
    fill_nxt = (fill_r == WIN_BITS'(MAX_WINDOW)) ? fill_r : fill_r + WIN_BITS'(1);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FR_IDLE: begin
        if (acc) begin
          state_nxt = FR_CALC;
        end
      end
      FR_CALC: state_nxt = FR_IDLE;
      default: state_nxt = FR_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != FR_IDLE) || q_full;
    q_push   = (state_r == FR_CALC);
    hist_we  = (state_r == FR_CALC);
  end

  assign acc   = in_valid && !in_stall;
  assign q_sum = sum_nxt;
  assign q_win = win_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= FR_IDLE;
      win_reg_r <= WINDOW_RESET;
      ptr_r     <= '0;
      fill_r    <= '0;
      sum_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        win_reg_r <= cfg_wdata;
        ptr_r     <= '0;
        fill_r    <= '0;
        sum_r     <= '0;
      end else if (q_push) begin
        ptr_r  <= ptr_nxt;
        fill_r <= fill_nxt;
        sum_r  <= sum_nxt;
      end
    end
  end

  // History ring: the leaving sample is read when the request is taken and
  // the new sample is written in the cycle after, from the FR_CALC state.
  always_ff @(posedge clk) begin
    if (acc) begin
      sample_r  <= in_sample;
      rd_data_r <= hist_r[old_idx[PTR_BITS-1:0]];
    end
    if (hist_we) begin
      hist_r[ptr_r] <= sample_r;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("front pushed into a full queue");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= WIN_BITS'(MAX_WINDOW))
    else $error("fill count beyond ring depth");
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PTR_BITS'(MAX_WINDOW - 1))
    else $error("ring pointer beyond ring depth");
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (sum_r == '0 && fill_r == '0 && ptr_r == '0))
    else $error("window write did not clear the history");
`endif

endmodule

>>> sv/maf_queue.sv
// Short queue between the front end and the divider of the moving average
// filter. Depends on nothing but its parameters.
module maf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wptr_r;
  logic [PTR_BITS-1:0] rptr_r;
  logic [CNT_BITS-1:0] count_r;

  assign full     = (count_r == CNT_BITS'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wptr_r + PTR_BITS'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rptr_r + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_BITS'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

>>> sv/maf_divider.sv
// Back end of the moving average filter: a restoring divider that turns each
// queued window sum into the average, truncated toward zero, plus the output
// register. Depends on maf_pkg.
module maf_divider import maf_pkg::*; #(
  parameter int  MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int  SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int WIN_BITS    = $clog2(MAX_WINDOW + 1),
  localparam int SUM_BITS    = SAMPLE_BITS + $clog2(MAX_WINDOW)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  logic signed [SUM_BITS-1:0]    q_sum,
  input  logic [WIN_BITS-1:0]           q_win,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_average
);

  localparam int CNT_BITS = $clog2(SUM_BITS + 1);

  div_state_t                    state_r, state_nxt;
  logic [CNT_BITS-1:0]           cnt_r;
  logic                          neg_r;
  logic [WIN_BITS-1:0]           div_r;
  logic [WIN_BITS-1:0]           rem_r;
  logic [SUM_BITS-1:0]           quo_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_average_r;

  logic [SUM_BITS-1:0]           mag;
  logic [WIN_BITS:0]             trial;
  logic [WIN_BITS:0]             diff;
  logic                          ge;
  logic [SUM_BITS-1:0]           res;
  logic                          out_free;
  logic                          load_out;

  // The magnitude of the most negative sum still fits unsigned.
  assign mag = q_sum[SUM_BITS-1] ? SUM_BITS'(-q_sum) : SUM_BITS'(q_sum);

  // One quotient bit per cycle; the dividend shifts out of the top of quo_r
  // as quotient bits shift in at the bottom.
  always_comb begin
    trial = {rem_r, quo_r[SUM_BITS-1]};
    diff  = trial - {1'b0, div_r};
    ge    = (trial >= {1'b0, div_r});
    res   = neg_r ? SUM_BITS'(-quo_r) : quo_r;
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DV_IDLE: begin
        if (!q_empty) begin
          state_nxt = DV_RUN;
        end
      end
      DV_RUN: begin
        if (cnt_r == CNT_BITS'(1)) begin
          state_nxt = DV_DONE;
        end
      end
      DV_DONE: begin
        if (out_free) begin
          state_nxt = DV_IDLE;
        end
      end
      default: state_nxt = DV_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state_r == DV_IDLE) && !q_empty;
    load_out = (state_r == DV_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= DV_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        cnt_r <= CNT_BITS'(SUM_BITS);
      end else if (state_r == DV_RUN) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      neg_r <= q_sum[SUM_BITS-1];
      div_r <= q_win;
      rem_r <= '0;
      quo_r <= mag;
    end else if (state_r == DV_RUN) begin
      rem_r <= ge ? diff[WIN_BITS-1:0] : trial[WIN_BITS-1:0];
      quo_r <= {quo_r[SUM_BITS-2:0], ge};
    end
    if (load_out) begin
      out_average_r <= res[SAMPLE_BITS-1:0];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

`ifndef SYNTHESIS
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == DV_RUN || state_r == DV_DONE) |-> rem_r < div_r)
    else $error("divider remainder not below divisor");
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == DV_RUN) |-> div_r != '0)
    else $error("divide by zero window");
  a_pop_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == DV_RUN && cnt_r == CNT_BITS'(SUM_BITS)))
    else $error("divider did not start after taking a sum");
`endif

endmodule

>>> sv/moving_average_filter.sv
// Moving average filter: top level joining front end, queue and divider.
// Depends on maf_pkg, maf_front, maf_queue and maf_divider.
//
// Each accepted sample gives one average: the sum of the last window_length
// samples (zero before the record starts or after a window write) divided by
// window_length, truncated toward zero. The front end handles a sample as a
// memory read, then a sum update and ring write, and takes no new sample
// until both are done or while the queue is full. The sustained rate is set
// by the restoring divider, which spends one cycle per sum bit. A two-entry
// queue lets the front end run ahead of the divider, and the output register
// lets the divider finish while a result waits. Reset and window writes need
// no clearing pass over the history ring; the block is ready in the cycle
// after either. Window 0 acts as 1 and values above MAX_WINDOW act as
// MAX_WINDOW. Write the window only while the block is idle.
module moving_average_filter import maf_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [WINDOW_REG_BITS-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_average
);

  localparam int WIN_BITS = $clog2(MAX_WINDOW + 1);
  localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int Q_WIDTH  = SUM_BITS + WIN_BITS;

  logic                       push;
  logic                       pop;
  logic                       q_full;
  logic                       q_empty;
  logic signed [SUM_BITS-1:0] f_sum;
  logic [WIN_BITS-1:0]        f_win;
  logic [Q_WIDTH-1:0]         push_data;
  logic [Q_WIDTH-1:0]         pop_data;

  maf_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .q_full    (q_full),
    .q_push    (push),
    .q_sum     (f_sum),
    .q_win     (f_win)
  );

  assign push_data = {f_sum, f_win};

  maf_queue #(
    .WIDTH (Q_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  maf_divider #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_divider (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_sum       (pop_data[Q_WIDTH-1:WIN_BITS]),
    .q_win       (pop_data[WIN_BITS-1:0]),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_average (out_average)
  );

endmodule

>>> tb/moving_average_filter_tb.sv
// Self-checking testbench for moving_average_filter: a directed table of requests and window
// writes, then randomized phases checked against an in-bench boxcar average predictor.
// Depends on maf_pkg and moving_average_filter.
module moving_average_filter_tb;
  import maf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int                            HOLD_CYCLES  = 200;
  localparam int                            HOLD_AT      = 500;
  localparam int                            DRAIN_CYCLES = 40;
  localparam int                            PHASES       = 12;
  localparam int                            PHASE_ITEMS  = 100;
  localparam logic signed [SAMPLE_BITS_DEF-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_BITS_DEF-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum int {
    MIX_UNIFORM,
    MIX_HIGH,
    MIX_LOW,
    MIX_SMALL
  } sample_mix_t;

  // One row of the directed table: either a window write or a sample,
  // with an optional hand-computed average.
  typedef struct packed {
    logic                              is_write;
    logic [WINDOW_REG_BITS-1:0]        window;
    logic signed [SAMPLE_BITS_DEF-1:0] sample;
    logic                              known;
    logic signed [SAMPLE_BITS_DEF-1:0] average;
  } step_t;

  localparam int DIRECTED_ROWS = 26;
  localparam step_t DIRECTED [DIRECTED_ROWS] = '{
    '{1'b0, 7'd0,   16'sd100,   1'b1, 16'sd5},      // reset window of 20
    '{1'b0, 7'd0,   SAMPLE_MIN, 1'b0, 16'sd0},
    '{1'b1, 7'd1,   16'sd0,     1'b0, 16'sd0},
    '{1'b0, 7'd0,   SAMPLE_MAX, 1'b1, SAMPLE_MAX},
    '{1'b0, 7'd0,   SAMPLE_MIN, 1'b1, SAMPLE_MIN},
    '{1'b0, 7'd0,   16'sd0,     1'b1, 16'sd0},
    '{1'b0, 7'd0,   -16'sd1,    1'b1, -16'sd1},
    '{1'b1, 7'd0,   16'sd0,     1'b0, 16'sd0},      // zero acts as one
    '{1'b0, 7'd0,   16'sd12345, 1'b1, 16'sd12345},
    '{1'b0, 7'd0,   -16'sd7,    1'b1, -16'sd7},
    '{1'b1, 7'd2,   16'sd0,     1'b0, 16'sd0},
    '{1'b0, 7'd0,   16'sd3,     1'b0, 16'sd0},
    '{1'b0, 7'd0,   -16'sd3,    1'b0, 16'sd0},
    '{1'b0, 7'd0,   -16'sd3,    1'b0, 16'sd0},
    '{1'b0, 7'd0,   -16'sd4,    1'b0, 16'sd0},      // odd negative sum
    '{1'b1, 7'd127, 16'sd0,     1'b0, 16'sd0},      // saturates to the ring depth
    '{1'b0, 7'd0,   SAMPLE_MAX, 1'b0, 16'sd0},
    '{1'b0, 7'd0,   SAMPLE_MIN, 1'b0, 16'sd0},
    '{1'b1, 7'd64,  16'sd0,     1'b0, 16'sd0},
    '{1'b0, 7'd0,   SAMPLE_MIN, 1'b1, -16'sd512},
    '{1'b0, 7'd0,   SAMPLE_MAX, 1'b0, 16'sd0},
    '{1'b1, 7'd65,  16'sd0,     1'b0, 16'sd0},
    '{1'b0, 7'd0,   16'sd1,     1'b0, 16'sd0},
    '{1'b1, 7'd20,  16'sd0,     1'b0, 16'sd0},      // same value as reset still clears
    '{1'b0, 7'd0,   SAMPLE_MAX, 1'b1, 16'sd1638},
    '{1'b0, 7'd0,   SAMPLE_MIN, 1'b0, 16'sd0}
  };

  localparam logic [WINDOW_REG_BITS-1:0] WINDOW_PLAN [8] = '{
    7'd64, 7'd1, 7'd127, 7'd0, 7'd2, 7'd65, 7'd63, 7'd3
  };

  logic                              clk;
  logic                              rst_n;
  logic                              cfg_we;
  logic [WINDOW_REG_BITS-1:0]        cfg_wdata;
  logic                              in_valid;
  logic                              in_stall;
  logic signed [SAMPLE_BITS_DEF-1:0] in_sample;
  logic                              out_valid;
  logic                              out_stall;
  logic signed [SAMPLE_BITS_DEF-1:0] out_average;

  // Hand-computed average riding along with the current request.
  logic                              in_known;
  logic signed [SAMPLE_BITS_DEF-1:0] in_known_average;

  // Predictor state.
  int                         ring [MAX_WINDOW_DEF];
  logic [5:0]                 ring_slot;
  int                         window_sum;
  logic [WINDOW_REG_BITS-1:0] window_reg;

  logic signed [SAMPLE_BITS_DEF-1:0] pending_averages [$];
  int                                averages_seen;
  int                                error_count;
  bit                                idle_on;

  moving_average_filter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_average (out_average)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void clear_ring();
    for (int i = 0; i < MAX_WINDOW_DEF; i++) ring[i] = 0;
    ring_slot  = '0;
    window_sum = 0;
  endfunction

  function automatic logic signed [SAMPLE_BITS_DEF-1:0] boxcar_average(
    input logic signed [SAMPLE_BITS_DEF-1:0] sample
  );
    int         span;
    logic [5:0] oldest;
    if (window_reg == 0) span = 1;
    else if (window_reg > MAX_WINDOW_DEF) span = MAX_WINDOW_DEF;
    else span = int'(window_reg);
    // The leaving sample is read before the new one lands; a full-depth window
    // therefore reads the very slot about to be overwritten.
    oldest = ring_slot - 6'(span);
    window_sum = window_sum - ring[oldest] + int'(sample);
    ring[ring_slot] = int'(sample);
    ring_slot = ring_slot + 6'd1;
    return SAMPLE_BITS_DEF'(window_sum / span);
  endfunction

  function automatic logic signed [SAMPLE_BITS_DEF-1:0] draw_sample(input sample_mix_t mix);
    logic signed [SAMPLE_BITS_DEF-1:0] v;
    v = SAMPLE_BITS_DEF'($urandom());
    case (mix)
      MIX_HIGH:  if ($urandom_range(0, 9) != 0) v = SAMPLE_MAX;
      MIX_LOW:   if ($urandom_range(0, 9) != 0) v = SAMPLE_MIN;
      MIX_SMALL: if ($urandom_range(0, 3) != 0) v = SAMPLE_BITS_DEF'(int'($urandom_range(0, 64)) - 32);
      default: ;
    endcase
    return v;
  endfunction

  // Predict on every accepted request and check every accepted result.
  always @(posedge clk) begin
    logic signed [SAMPLE_BITS_DEF-1:0] want;
    if (!rst_n) begin
      clear_ring();
      window_reg = WINDOW_RESET;
    end else begin
      if (cfg_we) begin
        window_reg = cfg_wdata;
        clear_ring();
      end
      if (in_valid && !in_stall) begin
        want = boxcar_average(in_sample);
        if (in_known) want = in_known_average;
        pending_averages = {pending_averages, want};
      end
      if (out_valid && !out_stall) begin
        averages_seen++;
        if (pending_averages.size() == 0) begin
          $error("average: expected none, got %0d", out_average);
          error_count++;
        end else begin
          want = pending_averages.pop_front();
          if (out_average !== want) begin
            $error("average: expected %0d, got %0d", want, out_average);
            error_count++;
          end
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off that lets the block fill up.
  initial begin
    int  gap;
    bit  held;
    held      = 1'b0;
    out_stall = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (!held && averages_seen >= HOLD_AT) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance with
  // valid still high, so a back-to-back request needs no second assignment.
  task automatic send_sample(input logic signed [SAMPLE_BITS_DEF-1:0] sample,
                             input logic known,
                             input logic signed [SAMPLE_BITS_DEF-1:0] average);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_sample        <= sample;
    in_known         <= known;
    in_known_average <= average;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    wait (pending_averages.size() == 0);
    @(negedge clk);
  endtask

  // The window register is only written once the pipeline has emptied.
  task automatic write_window(input logic [WINDOW_REG_BITS-1:0] value);
    drain_requests();
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    sample_mix_t                mix;
    logic [WINDOW_REG_BITS-1:0] window;
    error_count      = 0;
    averages_seen    = 0;
    idle_on          = 1'b1;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_sample        = '0;
    in_known         = 1'b0;
    in_known_average = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].is_write) write_window(DIRECTED[r].window);
      else send_sample(DIRECTED[r].sample, DIRECTED[r].known, DIRECTED[r].average);
    end

    for (int p = 0; p < PHASES; p++) begin
      window  = (p < 8) ? WINDOW_PLAN[p] : WINDOW_REG_BITS'($urandom_range(0, 127));
      mix     = sample_mix_t'(p % 4);
      idle_on = (p % 3 != 2);
      write_window(window);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Once, let everything in flight come out before going on.
        if (p == 3 && k == PHASE_ITEMS / 2) drain_requests();
        send_sample(draw_sample(mix), 1'b0, '0);
      end
    end

    drain_requests();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_averages.size() != 0) begin
      $error("average: %0d expected results never arrived", pending_averages.size());
      error_count++;
    end
    if (error_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
